>>> hdl/periodic_timer_table_defines.svh
// assertion macros for the periodic timer table
`ifndef PERIODIC_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_TIMER_TABLE_DEFINES_SVH

// same-cycle implication
`define PTT_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PTT_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/ptt_pkg.sv
// types, codes and sizes shared by the periodic timer table
`timescale 1ns / 1ps

package ptt_pkg;

   localparam int TIMER_SLOTS = 16;
   localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TIMER_SLOTS - 1);

   // request codes
   localparam logic [1:0] REQ_ADD  = 2'd0;
   localparam logic [1:0] REQ_KILL = 2'd1;
   localparam logic [1:0] REQ_TICK = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_ADD  = 2'd0;
   localparam logic [1:0] KIND_KILL = 2'd1;
   localparam logic [1:0] KIND_FIRE = 2'd2;
   localparam logic [1:0] KIND_DONE = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_KILL_RD,
      ST_KILL_CMP,
      ST_TICK_RD,
      ST_TICK_ELAP,
      ST_TICK_CNT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] period;
      logic [31:0] limit;
      logic [31:0] count;
      logic [31:0] elapsed;
   } slot_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      slot_type          data;
   } slot_wr_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] id;
      logic [31:0] count;
      logic        ok;
      logic        expired;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] cmp_val;
   } alu_in_type;

   typedef struct packed {
      logic [31:0] sum;
      logic        ge;
      logic        eq;
   } alu_out_type;

endpackage

>>> hdl/ptt_req_if.sv
// request channel of the periodic timer table
`timescale 1ns / 1ps

interface ptt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] amount;
   logic [31:0] repeat_limit;
   logic [31:0] timer_id;

   modport source (output valid, output req_type, output amount, output repeat_limit,
                   output timer_id, input ready);
   modport sink   (input valid, input req_type, input amount, input repeat_limit,
                   input timer_id, output ready);
endinterface

>>> hdl/ptt_rsp_if.sv
// result channel of the periodic timer table
`timescale 1ns / 1ps

interface ptt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  resp_kind;
   logic [31:0] resp_id;
   logic [31:0] fire_count;
   logic        ok;
   logic        expired;
   logic        last;

   modport source (output valid, output resp_kind, output resp_id, output fire_count,
                   output ok, output expired, output last, input ready);
   modport sink   (input valid, input resp_kind, input resp_id, input fire_count,
                   input ok, input expired, input last, output ready);
endinterface

>>> hdl/periodic_timer_table.sv
// top level of the periodic timer table
//
//   channel  direction  handshake     payload
//   req_ch   in         valid/ready   req_type, amount, repeat_limit, timer_id
//   rsp_ch   out        valid/ready   resp_kind, resp_id, fire_count, ok, expired, last
//
// one request at a time; ready is high only between requests
// add walks the live bits from slot 0 to the first free slot, visiting at most TIMER_SLOTS
// kill: free slots are skipped; a live slot is compared in ST_KILL_CMP after the memory read
// tick: states ST_TICK_RD, then ST_TICK_ELAP if live, ST_TICK_CNT if firing; ST_DONE ends
// results leave through an output register; a stalled result holds only emitting states
// synchronous reset frees every slot and clears the id counter
`timescale 1ns / 1ps
`include "periodic_timer_table_defines.svh"

module periodic_timer_table (
   input  logic      clock,
   input  logic      reset,
   ptt_req_if.sink   req_ch,
   ptt_rsp_if.source rsp_ch
);

   ptt_pkg::slot_type                 slot_rd;
   logic [ptt_pkg::SLOT_W-1:0]        slot_rd_addr;
   ptt_pkg::slot_wr_type              slot_wr;
   logic                              out_free;
   logic                              emit_valid;
   ptt_pkg::rsp_item_type             emit;
   logic                              rsp_valid_ff;
   ptt_pkg::rsp_item_type             rsp_item_ff;

   ptt_slot_ram u_ram (
      .clock   (clock),
      .slot_wr (slot_wr),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd)
   );

   ptt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .slot_rd      (slot_rd),
      .slot_rd_addr (slot_rd_addr),
      .slot_wr      (slot_wr),
      .out_free     (out_free),
      .emit_valid   (emit_valid),
      .emit         (emit)
   );

   // output register frees when empty or when the transaction completes
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= emit_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && emit_valid) begin
         rsp_item_ff <= emit;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.resp_kind  = rsp_item_ff.kind;
   assign rsp_ch.resp_id    = rsp_item_ff.id;
   assign rsp_ch.fire_count = rsp_item_ff.count;
   assign rsp_ch.ok         = rsp_item_ff.ok;
   assign rsp_ch.expired    = rsp_item_ff.expired;
   assign rsp_ch.last       = rsp_item_ff.last;

   // a known request keeps the block busy the next cycle
   `PTT_ASSERT_NXT(a_busy_after_req, clock, reset,
      req_ch.valid && req_ch.ready && (req_ch.req_type == ptt_pkg::REQ_ADD ||
      req_ch.req_type == ptt_pkg::REQ_KILL || req_ch.req_type == ptt_pkg::REQ_TICK),
      !req_ch.ready, "block ready right after taking a request")

   // a fire record never closes a tick and carries a counted firing
   `PTT_ASSERT_IMP(a_fire_shape, clock, reset,
      rsp_ch.valid && rsp_ch.resp_kind == ptt_pkg::KIND_FIRE,
      !rsp_ch.last && !rsp_ch.ok && rsp_ch.fire_count != '0, "malformed fire record")

   // the done record closes the tick
   `PTT_ASSERT_IMP(a_done_shape, clock, reset,
      rsp_ch.valid && rsp_ch.resp_kind == ptt_pkg::KIND_DONE,
      rsp_ch.last && rsp_ch.resp_id == '0, "malformed done record")

   // a successful add hands out a nonzero id
   `PTT_ASSERT_IMP(a_add_id_nonzero, clock, reset,
      rsp_ch.valid && rsp_ch.resp_kind == ptt_pkg::KIND_ADD && rsp_ch.ok,
      rsp_ch.resp_id != '0, "add succeeded with id zero")

endmodule

>>> hdl/ptt_alu.sv
// shared saturating adder and comparator for the kill id compare and the tick elapsed and count steps
`timescale 1ns / 1ps

module ptt_alu (
   input  ptt_pkg::alu_in_type  alu_in,
   output ptt_pkg::alu_out_type alu_out
);

   logic [32:0] raw_sum;

   // add with saturation, then compare the result and the plain operand
   always_comb begin
      raw_sum         = {1'b0, alu_in.a} + {1'b0, alu_in.b};
      alu_out.sum     = raw_sum[32] ? '1 : raw_sum[31:0];
      alu_out.ge      = (alu_out.sum >= alu_in.cmp_val);
      alu_out.eq      = (alu_in.a == alu_in.cmp_val);
   end

endmodule

>>> hdl/ptt_slot_ram.sv
// slot record memory: one write port, one registered read port
`timescale 1ns / 1ps

module ptt_slot_ram (
   input  logic                        clock,
   input  ptt_pkg::slot_wr_type        slot_wr,
   input  logic [ptt_pkg::SLOT_W-1:0]  rd_addr,
   output ptt_pkg::slot_type           rd_data
);

   ptt_pkg::slot_type mem_ff [ptt_pkg::TIMER_SLOTS];
   ptt_pkg::slot_type rd_data_ff;

   // write and read
   always_ff @(posedge clock) begin
      if (slot_wr.en) begin
         mem_ff[slot_wr.addr] <= slot_wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ptt_ctrl.sv
// sequencer that walks the slots for add, kill and tick
`timescale 1ns / 1ps

module ptt_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   ptt_req_if.sink                     req_ch,
   input  ptt_pkg::slot_type           slot_rd,
   output logic [ptt_pkg::SLOT_W-1:0]  slot_rd_addr,
   output ptt_pkg::slot_wr_type        slot_wr,
   input  logic                        out_free,
   output logic                        emit_valid,
   output ptt_pkg::rsp_item_type       emit
);

   ptt_pkg::state_type                state_ff, state_in;
   logic [ptt_pkg::SLOT_W-1:0]        idx_ff, idx_in;
   logic [ptt_pkg::TIMER_SLOTS-1:0]   live_ff, live_in;
   logic [31:0]                       next_id_ff, next_id_in;
   logic [31:0]                       amount_ff, amount_in;
   logic [31:0]                       limit_ff, limit_in;
   logic [31:0]                       tid_ff, tid_in;
   ptt_pkg::alu_in_type               alu_in;
   ptt_pkg::alu_out_type              alu_out;
   logic                              idx_last;
   logic                              cur_live;
   logic [31:0]                       id_inc;
   logic [31:0]                       new_id;
   logic                              expire;

   ptt_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

   assign idx_last     = (idx_ff == ptt_pkg::LAST_SLOT);
   assign cur_live     = live_ff[idx_ff];
   assign slot_rd_addr = idx_ff;
   assign req_ch.ready = (state_ff == ptt_pkg::ST_IDLE);

   // next id, wrapping past zero
   assign id_inc = next_id_ff + 32'd1;
   assign new_id = (id_inc == '0) ? 32'd1 : id_inc;

   // fire removes the timer once a nonzero limit is reached
   assign expire = (slot_rd.limit != '0) && alu_out.ge;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptt_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               case (req_ch.req_type)
                  ptt_pkg::REQ_ADD:  state_in = ptt_pkg::ST_ADD;
                  ptt_pkg::REQ_KILL: state_in = ptt_pkg::ST_KILL_RD;
                  ptt_pkg::REQ_TICK: state_in = ptt_pkg::ST_TICK_RD;
                  default:           state_in = ptt_pkg::ST_IDLE;
               endcase
            end
         end
         ptt_pkg::ST_ADD: begin
            if (out_free && (amount_ff == '0 || !cur_live || idx_last)) begin
               state_in = ptt_pkg::ST_IDLE;
            end
         end
         ptt_pkg::ST_KILL_RD: begin
            if (cur_live) begin
               state_in = ptt_pkg::ST_KILL_CMP;
            end else if (idx_last && out_free) begin
               state_in = ptt_pkg::ST_IDLE;
            end
         end
         ptt_pkg::ST_KILL_CMP: begin
            if (alu_out.eq || idx_last) begin
               if (out_free) begin
                  state_in = ptt_pkg::ST_IDLE;
               end
            end else begin
               state_in = ptt_pkg::ST_KILL_RD;
            end
         end
         ptt_pkg::ST_TICK_RD: begin
            if (cur_live) begin
               state_in = ptt_pkg::ST_TICK_ELAP;
            end else if (idx_last) begin
               state_in = ptt_pkg::ST_DONE;
            end
         end
         ptt_pkg::ST_TICK_ELAP: begin
            if (alu_out.ge) begin
               state_in = ptt_pkg::ST_TICK_CNT;
            end else begin
               state_in = idx_last ? ptt_pkg::ST_DONE : ptt_pkg::ST_TICK_RD;
            end
         end
         ptt_pkg::ST_TICK_CNT: begin
            if (out_free) begin
               state_in = idx_last ? ptt_pkg::ST_DONE : ptt_pkg::ST_TICK_RD;
            end
         end
         ptt_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = ptt_pkg::ST_IDLE;
            end
         end
         default: state_in = ptt_pkg::ST_IDLE;
      endcase
   end

   // datapath, slot writes and results
   always_comb begin
      idx_in       = idx_ff;
      live_in      = live_ff;
      next_id_in   = next_id_ff;
      amount_in    = amount_ff;
      limit_in     = limit_ff;
      tid_in       = tid_ff;
      slot_wr.en   = 1'b0;
      slot_wr.addr = idx_ff;
      slot_wr.data = slot_rd;
      emit_valid   = 1'b0;
      emit         = '0;
      emit.last    = 1'b1;

      // shared unit operands
      alu_in.a       = slot_rd.elapsed;
      alu_in.b       = amount_ff;
      alu_in.cmp_val = slot_rd.period;
      case (state_ff)
         ptt_pkg::ST_TICK_CNT: begin
            alu_in.a       = slot_rd.count;
            alu_in.b       = 32'd1;
            alu_in.cmp_val = slot_rd.limit;
         end
         ptt_pkg::ST_KILL_CMP: begin
            alu_in.a       = slot_rd.id;
            alu_in.b       = '0;
            alu_in.cmp_val = tid_ff;
         end
         default: ;
      endcase

      case (state_ff)
         ptt_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               amount_in = req_ch.amount;
               limit_in  = req_ch.repeat_limit;
               tid_in    = req_ch.timer_id;
               idx_in    = '0;
            end
         end
         ptt_pkg::ST_ADD: begin
            emit.kind = ptt_pkg::KIND_ADD;
            if (amount_ff == '0) begin
               emit_valid = out_free;
            end else if (!cur_live) begin
               if (out_free) begin
                  emit_valid           = 1'b1;
                  emit.id              = new_id;
                  emit.ok              = 1'b1;
                  next_id_in           = new_id;
                  live_in[idx_ff]      = 1'b1;
                  slot_wr.en           = 1'b1;
                  slot_wr.data.id      = new_id;
                  slot_wr.data.period  = amount_ff;
                  slot_wr.data.limit   = limit_ff;
                  slot_wr.data.count   = '0;
                  slot_wr.data.elapsed = '0;
               end
            end else if (idx_last) begin
               emit_valid = out_free;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ptt_pkg::ST_KILL_RD: begin
            emit.kind = ptt_pkg::KIND_KILL;
            emit.id   = tid_ff;
            if (!cur_live) begin
               if (idx_last) begin
                  emit_valid = out_free;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ptt_pkg::ST_KILL_CMP: begin
            emit.kind = ptt_pkg::KIND_KILL;
            emit.id   = tid_ff;
            if (alu_out.eq) begin
               emit.ok = 1'b1;
               if (out_free) begin
                  emit_valid      = 1'b1;
                  live_in[idx_ff] = 1'b0;
               end
            end else if (idx_last) begin
               emit_valid = out_free;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ptt_pkg::ST_TICK_RD: begin
            if (!cur_live && !idx_last) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ptt_pkg::ST_TICK_ELAP: begin
            // no fire: store the grown elapsed time and move on
            if (!alu_out.ge) begin
               slot_wr.en           = 1'b1;
               slot_wr.data.elapsed = alu_out.sum;
               if (!idx_last) begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ptt_pkg::ST_TICK_CNT: begin
            emit.kind    = ptt_pkg::KIND_FIRE;
            emit.id      = slot_rd.id;
            emit.count   = alu_out.sum;
            emit.expired = expire;
            emit.last    = 1'b0;
            if (out_free) begin
               emit_valid           = 1'b1;
               slot_wr.en           = 1'b1;
               slot_wr.data.count   = alu_out.sum;
               slot_wr.data.elapsed = '0;
               if (expire) begin
                  live_in[idx_ff] = 1'b0;
               end
               if (!idx_last) begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ptt_pkg::ST_DONE: begin
            emit.kind  = ptt_pkg::KIND_DONE;
            emit_valid = out_free;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ptt_pkg::ST_IDLE;
         live_ff    <= '0;
         next_id_ff <= '0;
      end else begin
         state_ff   <= state_in;
         live_ff    <= live_in;
         next_id_ff <= next_id_in;
      end
   end

   // request and walk registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      amount_ff <= amount_in;
      limit_ff  <= limit_in;
      tid_ff    <= tid_in;
   end

endmodule

>>> dv/timer_table_checker.sv
// scoreboard for the periodic timer table: mirrors the timer slots and checks every result
`timescale 1ns / 1ps

module timer_table_checker
   import ptt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   ptt_req_if   req_ch,
   ptt_rsp_if   rsp_ch,
   output int   mismatches,
   output int   outstanding
);

   // mirrored slot contents
   logic         slot_on     [TIMER_SLOTS];
   logic [31:0]  slot_tag    [TIMER_SLOTS];
   logic [31:0]  slot_period [TIMER_SLOTS];
   logic [31:0]  slot_lim    [TIMER_SLOTS];
   logic [31:0]  slot_fires  [TIMER_SLOTS];
   logic [31:0]  slot_accum  [TIMER_SLOTS];
   logic [31:0]  last_tag;

   // results still owed by the block, oldest first
   rsp_item_type rsp_due [$];
   int           error_tally = 0;

   function automatic rsp_item_type make_rsp(input logic [1:0] kind, input logic [31:0] id,
                                             input logic [31:0] cnt, input logic ok_b,
                                             input logic exp_b, input logic last_b);
      rsp_item_type item;
      item.kind    = kind;
      item.id      = id;
      item.count   = cnt;
      item.ok      = ok_b;
      item.expired = exp_b;
      item.last    = last_b;
      return item;
   endfunction

   // work out the results of one accepted request and update the mirror
   task automatic predict_request(input logic [1:0] op, input logic [31:0] amt,
                                  input logic [31:0] lim, input logic [31:0] tid);
      int          free_idx;
      logic        hit;
      logic        gone;
      logic [31:0] sum;
      free_idx = -1;
      hit      = 1'b0;
      case (op)
         REQ_ADD: begin
            for (int i = 0; i < TIMER_SLOTS; i++)
               if (!slot_on[i] && free_idx < 0) free_idx = i;
            if (amt == '0 || free_idx < 0) begin
               rsp_due.push_back(make_rsp(KIND_ADD, '0, '0, 1'b0, 1'b0, 1'b1));
            end else begin
               // id counter wraps past zero
               last_tag = last_tag + 32'd1;
               if (last_tag == '0) last_tag = 32'd1;
               slot_on[free_idx]     = 1'b1;
               slot_tag[free_idx]    = last_tag;
               slot_period[free_idx] = amt;
               slot_lim[free_idx]    = lim;
               slot_fires[free_idx]  = '0;
               slot_accum[free_idx]  = '0;
               rsp_due.push_back(make_rsp(KIND_ADD, last_tag, '0, 1'b1, 1'b0, 1'b1));
            end
         end
         REQ_KILL: begin
            // only the lowest matching slot is freed
            for (int i = 0; i < TIMER_SLOTS; i++) begin
               if (!hit && slot_on[i] && slot_tag[i] == tid) begin
                  slot_on[i] = 1'b0;
                  hit        = 1'b1;
               end
            end
            rsp_due.push_back(make_rsp(KIND_KILL, tid, '0, hit, 1'b0, 1'b1));
         end
         REQ_TICK: begin
            for (int i = 0; i < TIMER_SLOTS; i++) begin
               if (slot_on[i]) begin
                  // elapsed time saturates rather than wrapping
                  sum = slot_accum[i] + amt;
                  if (sum < amt) sum = '1;
                  slot_accum[i] = sum;
                  if (sum >= slot_period[i]) begin
                     slot_accum[i] = '0;
                     if (slot_fires[i] != '1) slot_fires[i] = slot_fires[i] + 32'd1;
                     gone = (slot_lim[i] != '0) && (slot_fires[i] >= slot_lim[i]);
                     if (gone) slot_on[i] = 1'b0;
                     rsp_due.push_back(make_rsp(KIND_FIRE, slot_tag[i], slot_fires[i],
                                                1'b0, gone, 1'b0));
                  end
               end
            end
            rsp_due.push_back(make_rsp(KIND_DONE, '0, '0, 1'b0, 1'b0, 1'b1));
         end
         default: ;  // unknown request: no results, no state change
      endcase
   endtask

   task automatic note_mismatch(input string what, input rsp_item_type want,
                                input rsp_item_type seen);
      error_tally++;
      if (error_tally <= 10) begin
         $display("%0t mismatch (%s): expected kind %0d id %h count %h ok %b exp %b last %b",
                  $realtime, what, want.kind, want.id, want.count, want.ok, want.expired,
                  want.last);
         $display("           got kind %0d id %h count %h ok %b exp %b last %b",
                  seen.kind, seen.id, seen.count, seen.ok, seen.expired, seen.last);
      end
   endtask

   // watch both channels at every edge
   always @(posedge clock) begin : watch
      rsp_item_type seen;
      rsp_item_type want;
      if (reset) begin
         for (int i = 0; i < TIMER_SLOTS; i++) slot_on[i] = 1'b0;
         last_tag = '0;
         rsp_due.delete();
      end else begin
         if (req_ch.valid && req_ch.ready)
            predict_request(req_ch.req_type, req_ch.amount, req_ch.repeat_limit,
                            req_ch.timer_id);
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen = make_rsp(rsp_ch.resp_kind, rsp_ch.resp_id, rsp_ch.fire_count, rsp_ch.ok,
                            rsp_ch.expired, rsp_ch.last);
            if (rsp_due.size() == 0) begin
               want = '0;
               note_mismatch("unexpected transaction", want, seen);
            end else begin
               want = rsp_due.pop_front();
               if (seen !== want) note_mismatch("field", want, seen);
            end
         end
      end
      mismatches  <= error_tally;
      outstanding <= rsp_due.size();
   end

endmodule

>>> dv/tb_periodic_timer_table.sv
// testbench top for the periodic timer table: stimulus, handshake idling and the verdict
`timescale 1ns / 1ps

module tb_periodic_timer_table;
   import ptt_pkg::*;

   localparam int         RANDOM_ITEMS  = 104;
   localparam int         HOLD_CYCLES   = 400;
   localparam int         QUIET_LIMIT   = 3000;
   localparam int         SETTLE_CYCLES = 100;
   localparam logic [1:0] REQ_UNKNOWN   = 2'd3;

   logic        clock;
   logic        reset;
   bit          gaps_on;
   bit          long_hold_go;
   int          mismatches;
   int          outstanding;
   int          quiet_cycles = 0;
   int unsigned ids_issued   = 0;

   ptt_req_if req_ch();
   ptt_rsp_if rsp_ch();

   periodic_timer_table dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   timer_table_checker scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random stalls plus one long hold-off
   initial begin : rsp_side
      bit hold_taken;
      hold_taken = 1'b0;
      rsp_ch.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (long_hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // offer one request, maybe after an idle burst, and wait until it is taken
   task automatic send_req(input logic [1:0] op, input logic [31:0] amt,
                           input logic [31:0] lim, input logic [31:0] tid);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.req_type     <= op;
      req_ch.amount       <= amt;
      req_ch.repeat_limit <= lim;
      req_ch.timer_id     <= tid;
      if (op == REQ_ADD && amt != '0) ids_issued++;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin : stimulus
      logic [1:0]  op;
      logic [31:0] amt;
      logic [31:0] lim;
      logic [31:0] tid;
      int          pick;
      int          sent;
      reset               <= 1'b1;
      gaps_on             <= 1'b1;
      long_hold_go        <= 1'b0;
      req_ch.valid        <= 1'b0;
      req_ch.req_type     <= REQ_ADD;
      req_ch.amount       <= '0;
      req_ch.repeat_limit <= '0;
      req_ch.timer_id     <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // zero period, kill of id 0 and an unknown request with every bit set
      send_req(REQ_ADD, '0, 32'd5, '0);
      send_req(REQ_KILL, '0, '0, '0);
      send_req(REQ_UNKNOWN, '1, '1, '1);

      // one-shot, unlimited at the largest period, two-shot, largest limit
      send_req(REQ_ADD, 32'd1, 32'd1, '0);
      send_req(REQ_ADD, '1, '0, '0);
      send_req(REQ_ADD, 32'd3, 32'd2, '0);
      send_req(REQ_ADD, 32'd2, '1, '0);

      // small tick, then the largest one so elapsed time saturates
      send_req(REQ_TICK, 32'd1, '0, '0);
      send_req(REQ_TICK, '1, '0, '0);
      send_req(REQ_KILL, '0, '0, 32'd2);

      // fill the table, overflow it, then fire every slot at once
      repeat (15) send_req(REQ_ADD, $urandom_range(1, 50), $urandom_range(0, 3), '0);
      send_req(REQ_ADD, 32'd9, '0, '0);
      send_req(REQ_TICK, '1, '0, '0);

      // random traffic
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         amt  = $urandom;
         lim  = $urandom;
         tid  = $urandom;
         pick = $urandom_range(0, 99);
         if (pick < 36) begin
            op  = REQ_ADD;
            amt = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 12);
            lim = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 4);
         end else if (pick < 60) begin
            op = REQ_KILL;
            case ($urandom_range(0, 9))
               0:       tid = '0;
               1:       tid = $urandom;
               default: tid = $urandom_range((ids_issued > 20) ? ids_issued - 20 : 1,
                                             ids_issued);
            endcase
         end else if (pick < 96) begin
            op  = REQ_TICK;
            amt = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6);
         end else begin
            op = REQ_UNKNOWN;
         end

         // stock fast timers, then flood ticks while the result side holds off
         if (sent >= 26 && sent < 30) begin
            op  = REQ_ADD;
            amt = 32'd1;
            lim = '0;
         end else if (sent >= 30 && sent < 38) begin
            op  = REQ_TICK;
            amt = $urandom_range(1, 4);
         end
         if (sent == 30) long_hold_go <= 1'b1;

         // sender pause until everything owed has come back
         if (sent == 70) wait_drained();

         // no idling in the closing stretch
         if (sent == RANDOM_ITEMS - 25) gaps_on <= 1'b0;

         send_req(op, amt, lim, tid);
         if (op != REQ_UNKNOWN) sent++;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hdl
hdl/ptt_pkg.sv
hdl/ptt_req_if.sv
hdl/ptt_rsp_if.sv
hdl/ptt_alu.sv
hdl/ptt_slot_ram.sv
hdl/ptt_ctrl.sv
hdl/periodic_timer_table.sv
dv/timer_table_checker.sv
dv/tb_periodic_timer_table.sv
